// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and index helpers for the double-ended queue.
// Used by the queue top level and by its port checker; no dependencies.
package deq_pkg;

   localparam int DEPTH  = 32;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      KIND_INS_FRONT = 3'd0,
      KIND_INS_BACK  = 3'd1,
      KIND_DEL_FRONT = 3'd2,
      KIND_DEL_BACK  = 3'd3,
      KIND_DUMP      = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_INVALID = 2'd3
   } status_type;

   // Next ring position, wrapping at the last entry.
   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   // Previous ring position, wrapping below the first entry.
   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
   endfunction

endpackage

// ===== rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps
// Double-ended queue of signed 32-bit values in a ring buffer memory.
// Timing: a result is registered in the cycle after its request transaction; the first result
// of a dump passes the read data register and then the result register, the front entry
// being read from memory first. A request is taken while the result register is free or
// being read; a dump holds off new requests up to its last result, one memory port read each.
// Reset (synchronous) empties the queue; memory contents are left as they are. Uses deq_pkg.
module double_ended_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [2:0]  req_tuser,   // [2:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] element
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   state_type                     state_ff, state_in;
   logic [deq_pkg::IDX_W-1:0]     front_ff, front_in;
   logic [deq_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [deq_pkg::IDX_W-1:0]     dump_pos_ff, dump_pos_in;
   logic [deq_pkg::CNT_W-1:0]     dump_left_ff, dump_left_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   deq_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [deq_pkg::DATA_W-1:0]    rsp_element_ff, rsp_element_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [deq_pkg::DATA_W-1:0]    mem [deq_pkg::DEPTH];
   logic [deq_pkg::DATA_W-1:0]    rd_data_ff;
   logic                          rd_en;
   logic [deq_pkg::IDX_W-1:0]     rd_addr;
   logic                          wr_en;
   logic [deq_pkg::IDX_W-1:0]     wr_addr;

   logic                          out_free;
   logic                          accept;
   logic                          full;
   logic                          empty;
   logic [deq_pkg::SUM_W-1:0]     back_sum;
   logic [deq_pkg::IDX_W-1:0]     back_idx;
   logic [deq_pkg::IDX_W-1:0]     front_dec;
   logic [deq_pkg::IDX_W-1:0]     dump_next;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == deq_pkg::CNT_W'(deq_pkg::DEPTH));
   assign empty      = (count_ff == '0);
   assign front_dec  = deq_pkg::idx_dec(front_ff);
   assign dump_next  = deq_pkg::idx_inc(dump_pos_ff);

   // The sum stays below twice the depth, so one conditional subtract wraps it.
   assign back_sum = deq_pkg::SUM_W'(front_ff) + deq_pkg::SUM_W'(count_ff);
   assign back_idx = (back_sum >= deq_pkg::SUM_W'(deq_pkg::DEPTH))
                   ? deq_pkg::IDX_W'(back_sum - deq_pkg::SUM_W'(deq_pkg::DEPTH))
                   : deq_pkg::IDX_W'(back_sum);

   always_comb begin
      state_in       = state_ff;
      front_in       = front_ff;
      count_in       = count_ff;
      dump_pos_in    = dump_pos_ff;
      dump_left_in   = dump_left_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      wr_addr        = front_dec;
      rd_en          = 1'b0;
      rd_addr        = front_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in   = 1'b1;
               rsp_element_in = '0;
               rsp_last_in    = 1'b1;
               rsp_status_in  = deq_pkg::STATUS_OK;
               case (deq_pkg::kind_type'(req_tuser))
                  deq_pkg::KIND_INS_FRONT: begin
                     if (full) begin
                        rsp_status_in = deq_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = front_dec;
                        front_in = front_dec;
                        count_in = count_ff + deq_pkg::CNT_W'(1);
                     end
                  end
                  deq_pkg::KIND_INS_BACK: begin
                     if (full) begin
                        rsp_status_in = deq_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = back_idx;
                        count_in = count_ff + deq_pkg::CNT_W'(1);
                     end
                  end
                  deq_pkg::KIND_DEL_FRONT: begin
                     if (empty) begin
                        rsp_status_in = deq_pkg::STATUS_EMPTY;
                     end else begin
                        front_in = deq_pkg::idx_inc(front_ff);
                        count_in = count_ff - deq_pkg::CNT_W'(1);
                     end
                  end
                  deq_pkg::KIND_DEL_BACK: begin
                     if (empty) begin
                        rsp_status_in = deq_pkg::STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - deq_pkg::CNT_W'(1);
                     end
                  end
                  deq_pkg::KIND_DUMP: begin
                     if (empty) begin
                        rsp_status_in = deq_pkg::STATUS_EMPTY;
                     end else begin
                        // Fetch the front entry now; results follow from the read data register.
                        rsp_valid_in = 1'b0;
                        rd_en        = 1'b1;
                        rd_addr      = front_ff;
                        dump_pos_in  = front_ff;
                        dump_left_in = count_ff;
                        state_in     = S_DUMP;
                     end
                  end
                  default: begin
                     rsp_status_in = deq_pkg::STATUS_INVALID;
                  end
               endcase
            end
         end
         S_DUMP: begin
            // The read data register holds the entry at dump_pos_ff here.
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = deq_pkg::STATUS_OK;
               rsp_element_in = rd_data_ff;
               rsp_last_in    = (dump_left_ff == deq_pkg::CNT_W'(1));
               if (dump_left_ff == deq_pkg::CNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en        = 1'b1;
                  rd_addr      = dump_next;
                  dump_pos_in  = dump_next;
                  dump_left_in = dump_left_ff - deq_pkg::CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dump_pos_ff    <= dump_pos_in;
      dump_left_ff   <= dump_left_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_tdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_element_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/deq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on deq_pkg for the status codes.
module deq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // No result is presented in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Only a dump gives several results, and all but its last carry an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == deq_pkg::STATUS_OK)
      else $error("non-final result without ok status");

   // An error status ends the transaction and carries no element.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != deq_pkg::STATUS_OK |-> rsp_tlast && rsp_tdata == '0)
      else $error("error result not final or element not zero");

   // No new request is taken while a dump is still being delivered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request accepted during a dump");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
